### rtl/core/pcoh_pkg.sv
// Shared types and constants for the pore classifier and orientation histograms.
package pcoh_pkg;

    // Widest histogram bin address for any supported bin count
    localparam int HIST_ADDR_W = 8;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [1:0] CFG_SPHERICITY = 2'd0;
    localparam logic [1:0] CFG_VOLUME     = 2'd1;
    localparam logic [1:0] CFG_ASPECT     = 2'd2;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IDLE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic                   keyhole;
        logic                   accepted;
        logic [31:0]            volume;
        logic [HIST_ADDR_W-1:0] az_bin;
        logic [HIST_ADDR_W-1:0] el_bin;
        logic [1:0]             sel;
        logic                   rd_ok;
    } front_item_t;

    typedef struct packed {
        logic        accepted;
        logic        keyhole;
        logic [47:0] total_volume;
        logic [47:0] accepted_volume;
        logic [31:0] keyhole_count;
        logic [31:0] gas_count;
        logic [31:0] bin_count;
        logic [47:0] bin_volume;
    } result_t;

endpackage

### rtl/core/pore_classify_orientation_histogram_top.sv
// Top level of the pore classifier with orientation histograms.
//
//  channel  | handshake            | transfer when         | payload
//  ---------+----------------------+-----------------------+----------------------------
//  input    | push / full          | push & !full          | operation .. bin_index
//  result   | empty / pop          | pop & !empty          | accepted .. bin_volume
//  config   | cfg_valid/cfg_ready  | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while the result side keeps popping; a result reaches
// the result ports after its input transfer through the input queue write, the
// histogram read, then the update and result queue write.
// The rate is set by the two-stage read-modify-write on the four histogram
// memories, with the just-written bin forwarded to the following item.
// Reset and the clear operation empty all histograms at once through per-bin
// valid bits; no clearing pass. Either side may stall; the input queue absorbs
// up to four items and the result queue four results.
module pore_classify_orientation_histogram_top #(
    parameter int BIN_COUNT = 18,
    parameter int BIN_WIDTH = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         operation,
    input  logic [15:0]        sphericity,
    input  logic [31:0]        pore_volume,
    input  logic signed [15:0] azimuth,
    input  logic signed [15:0] elevation,
    input  logic [15:0]        ratio_first_second,
    input  logic [15:0]        ratio_first_third,
    input  logic [1:0]         histogram_select,
    input  logic [4:0]         bin_index,
    output logic               empty,
    input  logic               pop,
    output logic               accepted,
    output logic               keyhole,
    output logic [47:0]        total_volume,
    output logic [47:0]        accepted_volume,
    output logic [31:0]        keyhole_count,
    output logic [31:0]        gas_count,
    output logic [31:0]        bin_count,
    output logic [47:0]        bin_volume
);

    localparam int MID_CW = $clog2(pcoh_pkg::MID_DEPTH + 1);
    localparam int OUT_CW = $clog2(pcoh_pkg::OUT_DEPTH + 1);

    pcoh_pkg::front_item_t front_item;
    pcoh_pkg::front_item_t mid_item;
    pcoh_pkg::result_t     back_result;
    pcoh_pkg::result_t     head_result;
    logic                  front_push;
    logic                  mid_full;
    logic                  mid_empty;
    logic [MID_CW-1:0]     mid_count;
    logic                  mid_pop;
    logic                  back_push;
    logic                  out_full;
    logic [OUT_CW-1:0]     out_count;

    assign full = mid_full;

    pcoh_front #(
        .BIN_COUNT (BIN_COUNT),
        .BIN_WIDTH (BIN_WIDTH)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .push               (push),
        .queue_full         (mid_full),
        .operation          (operation),
        .sphericity         (sphericity),
        .pore_volume        (pore_volume),
        .azimuth            (azimuth),
        .elevation          (elevation),
        .ratio_first_second (ratio_first_second),
        .ratio_first_third  (ratio_first_third),
        .histogram_select   (histogram_select),
        .bin_index          (bin_index),
        .item_push          (front_push),
        .item               (front_item)
    );

    pcoh_fifo #(
        .T     (pcoh_pkg::front_item_t),
        .DEPTH (pcoh_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .wdata (front_item),
        .pop   (mid_pop),
        .rdata (mid_item),
        .full  (mid_full),
        .empty (mid_empty),
        .count (mid_count)
    );

    pcoh_back #(
        .BIN_COUNT (BIN_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_item    (mid_item),
        .in_pop     (mid_pop),
        .out_count  (out_count),
        .out_push   (back_push),
        .out_result (back_result)
    );

    pcoh_fifo #(
        .T     (pcoh_pkg::result_t),
        .DEPTH (pcoh_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .wdata (back_result),
        .pop   (pop),
        .rdata (head_result),
        .full  (out_full),
        .empty (empty),
        .count (out_count)
    );

    assign accepted        = head_result.accepted;
    assign keyhole         = head_result.keyhole;
    assign total_volume    = head_result.total_volume;
    assign accepted_volume = head_result.accepted_volume;
    assign keyhole_count   = head_result.keyhole_count;
    assign gas_count       = head_result.gas_count;
    assign bin_count       = head_result.bin_count;
    assign bin_volume      = head_result.bin_volume;

endmodule

### rtl/core/pcoh_fifo.sv
// Small synchronous queue with occupancy count.
module pcoh_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  T              wdata,
    input  logic          pop,
    output T              rdata,
    output logic          full,
    output logic          empty,
    output logic [CW-1:0] count
);

    T              store [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store[rd_ptr_reg];

    always_comb
    begin
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/core/pcoh_front.sv
// Front end: configuration registers, pore classification and angle binning.
module pcoh_front #(
    parameter int BIN_COUNT = 18,
    parameter int BIN_WIDTH = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  push,
    input  logic                  queue_full,
    input  logic [1:0]            operation,
    input  logic [15:0]           sphericity,
    input  logic [31:0]           pore_volume,
    input  logic signed [15:0]    azimuth,
    input  logic signed [15:0]    elevation,
    input  logic [15:0]           ratio_first_second,
    input  logic [15:0]           ratio_first_third,
    input  logic [1:0]            histogram_select,
    input  logic [4:0]            bin_index,
    output logic                  item_push,
    output pcoh_pkg::front_item_t item
);

    localparam int ANGLE_W  = 15;
    localparam int DIVISOR  = BIN_WIDTH * 100;
    localparam int DIV_LOG  = $clog2(DIVISOR);
    localparam int SHIFT    = ANGLE_W + DIV_LOG;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int RECIP_W  = ANGLE_W + 2;
    localparam int PROD_W   = ANGLE_W + RECIP_W;
    localparam logic signed [16:0] HALF_TURN = 17'sd18000;

    logic [15:0]   sph_thr_reg;
    logic [31:0]   vol_thr_reg;
    logic [15:0]   aspect_thr_reg;
    pcoh_pkg::op_t op;
    logic          is_record;
    logic          is_keyhole;
    logic          is_read;
    logic          read_ok;

    // Fold negative angles by half a turn, then divide by the bin width through an exact
    // reciprocal multiply (valid for any 15-bit dividend).
    function automatic logic [pcoh_pkg::HIST_ADDR_W-1:0] angle_bin(
        input logic signed [15:0] angle
    );
        logic signed [16:0]  folded;
        logic [ANGLE_W-1:0]  mag;
        logic [PROD_W-1:0]   prod;
        logic [PROD_W-1:0]   quot;
        folded = (angle < 0) ? 17'(angle) + HALF_TURN : 17'(angle);
        if (folded < 0)
        begin
            return '0;
        end
        mag  = folded[ANGLE_W-1:0];
        prod = PROD_W'(mag) * PROD_W'(RECIP);
        quot = prod >> SHIFT;
        if (quot >= PROD_W'(BIN_COUNT))
        begin
            quot = PROD_W'(BIN_COUNT - 1);
        end
        return pcoh_pkg::HIST_ADDR_W'(quot);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sph_thr_reg    <= 16'hFFFF;
            vol_thr_reg    <= '0;
            aspect_thr_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pcoh_pkg::CFG_SPHERICITY: sph_thr_reg    <= cfg_data[15:0];
                pcoh_pkg::CFG_VOLUME:     vol_thr_reg    <= cfg_data;
                pcoh_pkg::CFG_ASPECT:     aspect_thr_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign op         = pcoh_pkg::op_t'(operation);
    assign is_record  = (op == pcoh_pkg::OP_RECORD);
    assign is_read    = (op == pcoh_pkg::OP_READ);
    assign is_keyhole = is_record && (sphericity <= sph_thr_reg) &&
                        ((ratio_first_second >= aspect_thr_reg) ||
                         (ratio_first_third >= aspect_thr_reg));
    assign read_ok    = is_read && (pcoh_pkg::HIST_ADDR_W'(bin_index) <
                                    pcoh_pkg::HIST_ADDR_W'(BIN_COUNT));
    assign item_push  = push && !queue_full;

    always_comb
    begin
        item          = '0;
        item.op       = op;
        item.keyhole  = is_keyhole;
        item.accepted = is_keyhole && (pore_volume >= vol_thr_reg);
        item.volume   = pore_volume;
        item.sel      = histogram_select;
        item.rd_ok    = read_ok;
        if (is_record)
        begin
            item.az_bin = angle_bin(azimuth);
            item.el_bin = angle_bin(elevation);
        end
        else if (read_ok)
        begin
            // a read looks up the same bin in all four histograms
            item.az_bin = pcoh_pkg::HIST_ADDR_W'(bin_index);
            item.el_bin = pcoh_pkg::HIST_ADDR_W'(bin_index);
        end
    end

endmodule

### rtl/core/pcoh_hist_bank.sv
// One histogram: count and volume memories, per-bin valid bits, write forwarding.
module pcoh_hist_bank #(
    parameter int BIN_COUNT = 18,
    localparam int AW = $clog2(BIN_COUNT)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          clear,
    input  logic          wr_en,
    input  logic [31:0]   wr_count,
    input  logic [47:0]   wr_volume,
    output logic [31:0]   old_count,
    output logic [47:0]   old_volume
);

    logic [31:0]          count_mem  [BIN_COUNT];
    logic [47:0]          volume_mem [BIN_COUNT];
    logic [31:0]          count_q_reg;
    logic [47:0]          volume_q_reg;
    logic [AW-1:0]        addr_reg;
    logic [BIN_COUNT-1:0] valid_reg;
    logic                 fwd_en_reg;
    logic [AW-1:0]        fwd_addr_reg;
    logic [31:0]          fwd_count_reg;
    logic [47:0]          fwd_volume_reg;
    logic                 fwd_hit;

    // writes go back to the address read in the previous cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[addr_reg]  <= wr_count;
            volume_mem[addr_reg] <= wr_volume;
        end
        if (rd_en)
        begin
            count_q_reg  <= count_mem[rd_addr];
            volume_q_reg <= volume_mem[rd_addr];
            addr_reg     <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else if (clear)
        begin
            valid_reg  <= '0;
            fwd_en_reg <= 1'b0;
        end
        else
        begin
            fwd_en_reg <= wr_en;
            if (wr_en)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= addr_reg;
        if (wr_en)
        begin
            fwd_count_reg  <= wr_count;
            fwd_volume_reg <= wr_volume;
        end
    end

    // the read that crossed a write in the same cycle takes the written data
    assign fwd_hit = fwd_en_reg && (fwd_addr_reg == addr_reg);

    always_comb
    begin
        if (fwd_hit)
        begin
            old_count  = fwd_count_reg;
            old_volume = fwd_volume_reg;
        end
        else if (valid_reg[addr_reg])
        begin
            old_count  = count_q_reg;
            old_volume = volume_q_reg;
        end
        else
        begin
            old_count  = '0;
            old_volume = '0;
        end
    end

endmodule

### rtl/core/pcoh_back.sv
// Back end: histogram read-modify-write, running sums and counts, result build.
module pcoh_back #(
    parameter int BIN_COUNT = 18,
    localparam int CW = $clog2(pcoh_pkg::OUT_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  pcoh_pkg::front_item_t in_item,
    output logic                  in_pop,
    input  logic [CW-1:0]         out_count,
    output logic                  out_push,
    output pcoh_pkg::result_t     out_result
);

    localparam int AW = $clog2(BIN_COUNT);

    logic                  b1_valid_reg;
    pcoh_pkg::front_item_t b1_item_reg;
    logic [47:0]           total_reg;
    logic [47:0]           total_next;
    logic [47:0]           acc_vol_reg;
    logic [47:0]           acc_vol_next;
    logic [31:0]           kh_cnt_reg;
    logic [31:0]           kh_cnt_next;
    logic [31:0]           gas_cnt_reg;
    logic [31:0]           gas_cnt_next;
    logic                  issue;
    logic                  hist_clear;
    logic                  rec_b1;
    logic [AW-1:0]         rd_addr    [4];
    logic                  wr_en      [4];
    logic [31:0]           old_count  [4];
    logic [47:0]           old_volume [4];
    logic [31:0]           new_count  [4];
    logic [47:0]           new_volume [4];

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        return (a == {32{1'b1}}) ? a : a + 32'd1;
    endfunction

    // room is reserved in the result queue before a histogram read is issued
    assign issue  = in_valid && ((CW + 1)'(out_count) + (CW + 1)'(b1_valid_reg) <
                                 (CW + 1)'(pcoh_pkg::OUT_DEPTH));
    assign in_pop = issue;
    assign rec_b1 = b1_valid_reg && (b1_item_reg.op == pcoh_pkg::OP_RECORD);

    genvar h;
    generate
        for (h = 0; h < 4; h++)
        begin : g_hist
            // histograms 0 and 1 take azimuth, 2 and 3 elevation
            assign rd_addr[h]    = (h < 2) ? in_item.az_bin[AW-1:0] : in_item.el_bin[AW-1:0];
            assign wr_en[h]      = rec_b1 && (((h % 2) == 0) || b1_item_reg.accepted);
            assign new_count[h]  = sat_inc32(old_count[h]);
            assign new_volume[h] = sat_add48(old_volume[h], {16'd0, b1_item_reg.volume});

            pcoh_hist_bank #(
                .BIN_COUNT (BIN_COUNT)
            ) u_bank (
                .clk        (clk),
                .rst_n      (rst_n),
                .rd_en      (issue),
                .rd_addr    (rd_addr[h]),
                .clear      (hist_clear),
                .wr_en      (wr_en[h]),
                .wr_count   (new_count[h]),
                .wr_volume  (new_volume[h]),
                .old_count  (old_count[h]),
                .old_volume (old_volume[h])
            );
        end
    endgenerate

    always_comb
    begin
        total_next   = total_reg;
        acc_vol_next = acc_vol_reg;
        kh_cnt_next  = kh_cnt_reg;
        gas_cnt_next = gas_cnt_reg;
        hist_clear   = 1'b0;
        if (b1_valid_reg)
        begin
            case (b1_item_reg.op)
                pcoh_pkg::OP_RECORD:
                begin
                    total_next = sat_add48(total_reg, {16'd0, b1_item_reg.volume});
                    if (b1_item_reg.accepted)
                    begin
                        acc_vol_next = sat_add48(acc_vol_reg, {16'd0, b1_item_reg.volume});
                    end
                    if (b1_item_reg.keyhole)
                    begin
                        kh_cnt_next = sat_inc32(kh_cnt_reg);
                    end
                    else
                    begin
                        gas_cnt_next = sat_inc32(gas_cnt_reg);
                    end
                end
                pcoh_pkg::OP_CLEAR:
                begin
                    total_next   = '0;
                    acc_vol_next = '0;
                    kh_cnt_next  = '0;
                    gas_cnt_next = '0;
                    hist_clear   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_result                 = '0;
        out_result.accepted        = b1_item_reg.accepted;
        out_result.keyhole         = b1_item_reg.keyhole;
        out_result.total_volume    = total_next;
        out_result.accepted_volume = acc_vol_next;
        out_result.keyhole_count   = kh_cnt_next;
        out_result.gas_count       = gas_cnt_next;
        if ((b1_item_reg.op == pcoh_pkg::OP_READ) && b1_item_reg.rd_ok)
        begin
            out_result.bin_count  = old_count[b1_item_reg.sel];
            out_result.bin_volume = old_volume[b1_item_reg.sel];
        end
    end

    assign out_push = b1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            total_reg    <= '0;
            acc_vol_reg  <= '0;
            kh_cnt_reg   <= '0;
            gas_cnt_reg  <= '0;
        end
        else
        begin
            b1_valid_reg <= issue;
            total_reg    <= total_next;
            acc_vol_reg  <= acc_vol_next;
            kh_cnt_reg   <= kh_cnt_next;
            gas_cnt_reg  <= gas_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b1_item_reg <= in_item;
        end
    end

endmodule

### tb/pcoh_tb_pkg.sv
// Scoreboard for the pore classifier: tally and histogram predictor with in-order result check.
package pcoh_tb_pkg;
    import pcoh_pkg::*;

    localparam int HIST_BINS   = 18;
    localparam int BIN_DEGREES = 10;
    localparam int HIST_SLOTS  = 4 * HIST_BINS;
    localparam int HALF_TURN   = 18000;
    localparam int PRINT_CAP   = 100;

    localparam logic [1:0] HIST_AZ_ALL = 2'd0;
    localparam logic [1:0] HIST_AZ_ACC = 2'd1;
    localparam logic [1:0] HIST_EL_ALL = 2'd2;
    localparam logic [1:0] HIST_EL_ACC = 2'd3;

    typedef struct packed {
        op_t                operation;
        logic [15:0]        sphericity;
        logic [31:0]        pore_volume;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic [15:0]        ratio_first_second;
        logic [15:0]        ratio_first_third;
        logic [1:0]         histogram_select;
        logic [4:0]         bin_index;
    } pore_item_t;

    class pore_tally_board;
        logic [15:0] sph_limit;
        logic [31:0] vol_limit;
        logic [15:0] aspect_limit;

        logic [47:0] total_vol;
        logic [47:0] accepted_vol;
        logic [31:0] keyhole_n;
        logic [31:0] gas_n;
        logic [31:0] bin_n [HIST_SLOTS];
        logic [47:0] bin_vol [HIST_SLOTS];

        result_t     due_tallies [$];
        int          mismatches;
        int          checked;

        function new();
            sph_limit    = 16'hFFFF;
            vol_limit    = '0;
            aspect_limit = 16'd256;
            mismatches   = 0;
            checked      = 0;
            wipe();
        endfunction

        function void wipe();
            total_vol    = '0;
            accepted_vol = '0;
            keyhole_n    = '0;
            gas_n        = '0;
            foreach (bin_n[i])
            begin
                bin_n[i]   = '0;
                bin_vol[i] = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SPHERICITY: sph_limit = data[15:0];
                CFG_VOLUME:     vol_limit = data;
                CFG_ASPECT:     aspect_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_tallies.size();
        endfunction

        function logic [47:0] add48(logic [47:0] a, logic [47:0] b);
            logic [48:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
        endfunction

        function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // Fold negatives by half a turn; anything still negative lands in bin 0,
        // anything past the last edge is clamped into the last bin.
        function int angle_bin(logic signed [15:0] raw);
            int a;
            int b;
            a = raw;
            if (a < 0)
                a += HALF_TURN;
            if (a < 0)
                return 0;
            b = a / (BIN_DEGREES * 100);
            if (b >= HIST_BINS)
                b = HIST_BINS - 1;
            return b;
        endfunction

        function void bump(logic [1:0] hist, int bin, logic [31:0] vol);
            int slot;
            slot = int'(hist) * HIST_BINS + bin;
            bin_n[slot]   = add32(bin_n[slot], 32'd1);
            bin_vol[slot] = add48(bin_vol[slot], {16'd0, vol});
        endfunction

        function void take_item(pore_item_t it);
            result_t r;
            int      az;
            int      el;
            int      slot;
            logic    kh;
            logic    acc;
            r = '0;
            case (it.operation)
                OP_RECORD:
                begin
                    az  = angle_bin(it.azimuth);
                    el  = angle_bin(it.elevation);
                    kh  = (it.sphericity <= sph_limit) &&
                          (it.ratio_first_second >= aspect_limit ||
                           it.ratio_first_third >= aspect_limit);
                    acc = kh && (it.pore_volume >= vol_limit);
                    total_vol = add48(total_vol, {16'd0, it.pore_volume});
                    bump(HIST_AZ_ALL, az, it.pore_volume);
                    bump(HIST_EL_ALL, el, it.pore_volume);
                    if (acc)
                    begin
                        accepted_vol = add48(accepted_vol, {16'd0, it.pore_volume});
                        bump(HIST_AZ_ACC, az, it.pore_volume);
                        bump(HIST_EL_ACC, el, it.pore_volume);
                    end
                    if (kh)
                        keyhole_n = add32(keyhole_n, 32'd1);
                    else
                        gas_n = add32(gas_n, 32'd1);
                    r.accepted = acc;
                    r.keyhole  = kh;
                end
                OP_READ:
                begin
                    if (it.bin_index < HIST_BINS)
                    begin
                        slot = it.histogram_select * HIST_BINS + it.bin_index;
                        r.bin_count  = bin_n[slot];
                        r.bin_volume = bin_vol[slot];
                    end
                end
                OP_CLEAR:
                    wipe();
                default: ;
            endcase
            r.total_volume    = total_vol;
            r.accepted_volume = accepted_vol;
            r.keyhole_count   = keyhole_n;
            r.gas_count       = gas_n;
            due_tallies.insert(due_tallies.size(), r);
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP)
                $display("MISMATCH result %0d: %s", checked, msg);
            mismatches++;
        endtask

        task compare(string name, logic [47:0] got, logic [47:0] want);
            if (got !== want)
                report($sformatf("%s is %0h, expected %0h", name, got, want));
        endtask

        task check_tally(result_t got);
            result_t want;
            if (due_tallies.size() == 0)
            begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = due_tallies.pop_front();
            compare("accepted", got.accepted, want.accepted);
            compare("keyhole", got.keyhole, want.keyhole);
            compare("total_volume", got.total_volume, want.total_volume);
            compare("accepted_volume", got.accepted_volume, want.accepted_volume);
            compare("keyhole_count", got.keyhole_count, want.keyhole_count);
            compare("gas_count", got.gas_count, want.gas_count);
            compare("bin_count", got.bin_count, want.bin_count);
            compare("bin_volume", got.bin_volume, want.bin_volume);
            checked++;
        endtask
    endclass

endpackage

### tb/pore_classify_orientation_histogram_top_tb.sv
// Testbench for the pore classifier: directed and random pore streams checked against a predictor.
module pore_classify_orientation_histogram_top_tb;
    import pcoh_pkg::*;
    import pcoh_tb_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 190;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               push;
    logic               full;
    logic [1:0]         operation;
    logic [15:0]        sphericity;
    logic [31:0]        pore_volume;
    logic signed [15:0] azimuth;
    logic signed [15:0] elevation;
    logic [15:0]        ratio_first_second;
    logic [15:0]        ratio_first_third;
    logic [1:0]         histogram_select;
    logic [4:0]         bin_index;
    logic               empty;
    logic               pop;
    logic               accepted;
    logic               keyhole;
    logic [47:0]        total_volume;
    logic [47:0]        accepted_volume;
    logic [31:0]        keyhole_count;
    logic [31:0]        gas_count;
    logic [31:0]        bin_count;
    logic [47:0]        bin_volume;

    pore_tally_board sb;
    bit              calm = 1'b0;

    pore_classify_orientation_histogram_top #(
        .BIN_COUNT (HIST_BINS),
        .BIN_WIDTH (BIN_DEGREES)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .push               (push),
        .full               (full),
        .operation          (operation),
        .sphericity         (sphericity),
        .pore_volume        (pore_volume),
        .azimuth            (azimuth),
        .elevation          (elevation),
        .ratio_first_second (ratio_first_second),
        .ratio_first_third  (ratio_first_third),
        .histogram_select   (histogram_select),
        .bin_index          (bin_index),
        .empty              (empty),
        .pop                (pop),
        .accepted           (accepted),
        .keyhole            (keyhole),
        .total_volume       (total_volume),
        .accepted_volume    (accepted_volume),
        .keyhole_count      (keyhole_count),
        .gas_count          (gas_count),
        .bin_count          (bin_count),
        .bin_volume         (bin_volume)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic pore_item_t rec(logic [15:0] sph, logic [31:0] vol,
                                       logic signed [15:0] az, logic signed [15:0] el,
                                       logic [15:0] r12, logic [15:0] r13);
        pore_item_t it;
        it = '0;
        it.operation          = OP_RECORD;
        it.sphericity         = sph;
        it.pore_volume        = vol;
        it.azimuth            = az;
        it.elevation          = el;
        it.ratio_first_second = r12;
        it.ratio_first_third  = r13;
        return it;
    endfunction

    function automatic pore_item_t ask(op_t op, logic [1:0] sel, logic [4:0] idx);
        pore_item_t it;
        it = '0;
        it.operation        = op;
        it.histogram_select = sel;
        it.bin_index        = idx;
        return it;
    endfunction

    function automatic logic [15:0] near16(logic [15:0] centre);
        case ($urandom_range(3))
            0:       return centre;
            1:       return centre + 16'd1;
            2:       return centre - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] near32(logic [31:0] centre);
        case ($urandom_range(3))
            0:       return centre;
            1:       return centre + 32'd1;
            2:       return centre - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_angle();
        int a;
        case ($urandom_range(9))
            0:       return 16'($urandom);
            // straddle a bin edge
            1, 2:
            begin
                a = int'($urandom_range(36)) * 1000 - HALF_TURN + int'($urandom_range(2)) - 1;
                return 16'(a);
            end
            default:
            begin
                a = int'($urandom_range(36000)) - HALF_TURN;
                return 16'(a);
            end
        endcase
    endfunction

    function automatic pore_item_t random_item();
        pore_item_t it;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 72)
            it.operation = OP_RECORD;
        else if (roll < 92)
            it.operation = OP_READ;
        else if (roll < 94)
            it.operation = OP_CLEAR;
        else
            it.operation = OP_IDLE;
        it.sphericity         = near16(sb.sph_limit);
        it.pore_volume        = $urandom_range(1) ? near32(sb.vol_limit) : $urandom;
        it.azimuth            = pick_angle();
        it.elevation          = pick_angle();
        it.ratio_first_second = near16(sb.aspect_limit);
        it.ratio_first_third  = near16(sb.aspect_limit);
        it.histogram_select   = 2'($urandom);
        if ($urandom_range(6) == 0)
            it.bin_index = 5'($urandom_range(31, HIST_BINS));
        else
            it.bin_index = 5'($urandom_range(HIST_BINS - 1));
        return it;
    endfunction

    task automatic send_item(input pore_item_t it);
        while (!calm && $urandom_range(99) < 24)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push               <= 1'b1;
        operation          <= it.operation;
        sphericity         <= it.sphericity;
        pore_volume        <= it.pore_volume;
        azimuth            <= it.azimuth;
        elevation          <= it.elevation;
        ratio_first_second <= it.ratio_first_second;
        ratio_first_third  <= it.ratio_first_third;
        histogram_select   <= it.histogram_select;
        bin_index          <= it.bin_index;
        do
            @(posedge clk);
        while (full);
        sb.take_item(it);
    endtask

    // cfg_valid is held by the caller across consecutive writes
    task automatic put_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic load_thresholds(input logic [15:0] sph, input logic [31:0] vol,
                                   input logic [15:0] asp);
        cfg_valid <= 1'b1;
        put_reg(CFG_SPHERICITY, {16'd0, sph});
        put_reg(CFG_VOLUME, vol);
        put_reg(CFG_ASPECT, {16'd0, asp});
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result side: random pop, plus one long hold-off so the input side backs up
    initial
    begin : result_side
        result_t seen;
        int      taken;
        bit      held;
        taken = 0;
        held  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.accepted        = accepted;
                seen.keyhole         = keyhole;
                seen.total_volume    = total_volume;
                seen.accepted_volume = accepted_volume;
                seen.keyhole_count   = keyhole_count;
                seen.gas_count       = gas_count;
                seen.bin_count       = bin_count;
                seen.bin_volume      = bin_volume;
                sb.check_tally(seen);
                taken++;
            end
            if (!held && taken == HOLD_AT)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                pop <= calm || ($urandom_range(99) >= 24);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] sph;
        logic [31:0] vol;
        logic [15:0] asp;
        sb = new();
        rst_n              <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= CFG_SPHERICITY;
        cfg_data           <= '0;
        push               <= 1'b0;
        pop                <= 1'b0;
        operation          <= OP_RECORD;
        sphericity         <= '0;
        pore_volume        <= '0;
        azimuth            <= '0;
        elevation          <= '0;
        ratio_first_second <= '0;
        ratio_first_third  <= '0;
        histogram_select   <= '0;
        bin_index          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, reset thresholds
        send_item(rec(16'h0000, 32'h0000_0000, 0, 0, 16'h0000, 16'h0000));
        send_item(rec(16'hFFFF, 32'hFFFF_FFFF, -18000, 18000, 16'h0100, 16'h0000));
        // still negative after folding, and far past the last edge
        send_item(rec(16'hFFFF, 32'hFFFF_FFFF, -32768, 32767, 16'h0000, 16'hFFFF));
        send_item(rec(16'h1234, 32'h0000_0005, -1, 17999, 16'h00FF, 16'h00FF));
        send_item(rec(16'h0000, 32'h0000_03E8, 999, 1000, 16'h0100, 16'h0100));
        send_item(rec(16'h9C40, 32'h0000_004D, 17000, -9000, 16'hFFFF, 16'hFFFF));
        send_item(rec(16'h0000, 32'h0000_0002, -17001, -18001, 16'h0000, 16'h0000));
        send_item(ask(OP_READ, HIST_AZ_ALL, 5'd0));
        send_item(ask(OP_READ, HIST_AZ_ACC, 5'd0));
        send_item(ask(OP_READ, HIST_EL_ALL, 5'd17));
        send_item(ask(OP_READ, HIST_EL_ACC, 5'd17));
        send_item(ask(OP_READ, HIST_AZ_ALL, 5'd17));
        send_item(ask(OP_READ, HIST_EL_ALL, 5'd9));
        send_item(ask(OP_READ, HIST_AZ_ACC, 5'd18));
        send_item(ask(OP_READ, HIST_EL_ACC, 5'd31));
        send_item(ask(OP_IDLE, HIST_AZ_ALL, 5'd0));
        send_item(ask(OP_CLEAR, HIST_AZ_ALL, 5'd0));
        send_item(ask(OP_READ, HIST_AZ_ALL, 5'd0));
        send_item(rec(16'h0001, 32'h0000_0100, 12345, -12345, 16'h0200, 16'h0000));
        send_item(ask(OP_READ, HIST_EL_ACC, 5'd5));
        send_item(ask(OP_READ, HIST_AZ_ACC, 5'd12));
        push <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    sph = 16'h0000;
                    vol = 32'h0000_0000;
                    asp = 16'h0000;
                end
                1:
                begin
                    sph = 16'hFFFF;
                    vol = 32'hFFFF_FFFF;
                    asp = 16'hFFFF;
                end
                default:
                begin
                    sph = 16'($urandom);
                    vol = $urandom_range(1) ? $urandom : 32'($urandom_range(4095));
                    asp = 16'($urandom);
                end
            endcase
            load_thresholds(sph, vol, asp);
            calm = (ph == 2);
            repeat (PHASE_ITEMS) send_item(random_item());
            push <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pcoh_pkg.sv
rtl/core/pcoh_fifo.sv
rtl/core/pcoh_front.sv
rtl/core/pcoh_hist_bank.sv
rtl/core/pcoh_back.sv
rtl/core/pore_classify_orientation_histogram_top.sv
tb/pcoh_tb_pkg.sv
tb/pore_classify_orientation_histogram_top_tb.sv
